// ===== rtl/core/fsab_pkg.sv =====
package fsab_pkg;

	// field widths
	localparam int SRC_W   = 13;
	localparam int AREA_W  = 11;
	localparam int MARG_W  = 4;
	localparam int COLOR_W = 16;
	localparam int CH_W    = 8;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;

	// product and accumulator widths
	localparam int PROD_W = AREA_W + SRC_W;     // area x source
	localparam int ACC_W  = SRC_W + SRC_W;      // index x scale term
	localparam int DVD_W  = 24;                 // source x scale numerator

	localparam logic [ACC_W-1:0] PIXEL_LIMIT = ACC_W'(1500000);
	localparam logic [SRC_W-1:0] ROW_MAX     = SRC_W'(8191);
	localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'd255;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_AREA_WIDTH    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_AREA_HEIGHT   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_MARGIN        = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_BACKGROUND    = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_SCALE,
		ST_DIVW_GO,
		ST_DIVW_WAIT,
		ST_DIVH_GO,
		ST_DIVH_WAIT,
		ST_FIN,
		ST_PIX
	} state_t;

	typedef struct packed {
		logic latch;      // hold the frame start pixel
		logic calc;       // sample sizes, reject check, cross products
		logic scale;      // pick scale fraction
		logic div_go;     // launch draw size division
		logic div_h;      // division is for the height
		logic cap_w;      // take draw width from divider
		logic cap_h;      // take draw height from divider
		logic fin;        // offsets and counter restart
		logic step_in;    // process pixel from the input port
		logic step_hold;  // process held pixel
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic rejected;
		logic div_done;
	} status_t;

endpackage

// ===== rtl/core/fsab_div.sv =====
module fsab_div #(
	parameter int DVD_W = 24,
	parameter int DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/fsab_ctrl.sv =====
module fsab_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             frame_start,
	output logic             in_ready,
	input  fsab_pkg::status_t status,
	output fsab_pkg::cmd_t   cmd
);
	import fsab_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.out_free && frame_start) state_d = ST_CALC;
			end
			ST_CALC:  state_d = ST_SCALE;
			ST_SCALE: state_d = status.rejected ? ST_FIN : ST_DIVW_GO;
			ST_DIVW_GO: state_d = ST_DIVW_WAIT;
			ST_DIVW_WAIT: begin
				if (status.div_done) state_d = ST_DIVH_GO;
			end
			ST_DIVH_GO: state_d = ST_DIVH_WAIT;
			ST_DIVH_WAIT: begin
				if (status.div_done) state_d = ST_FIN;
			end
			ST_FIN: state_d = ST_PIX;
			ST_PIX: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = status.out_free;
				cmd.latch     = in_valid && status.out_free && frame_start;
				cmd.step_in   = in_valid && status.out_free && !frame_start;
			end
			ST_CALC:  cmd.calc  = 1'b1;
			ST_SCALE: cmd.scale = 1'b1;
			ST_DIVW_GO: cmd.div_go = 1'b1;
			ST_DIVW_WAIT: cmd.cap_w = status.div_done;
			ST_DIVH_GO: begin
				cmd.div_go = 1'b1;
				cmd.div_h  = 1'b1;
			end
			ST_DIVH_WAIT: cmd.cap_h = status.div_done;
			ST_FIN: cmd.fin = 1'b1;
			ST_PIX: cmd.step_hold = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/fsab_dp.sv =====
module fsab_dp #(
	parameter int MAX_SOURCE_DIM = 4096,
	parameter int MAX_AREA_DIM   = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fsab_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [fsab_pkg::CDATA_W-1:0]  cfg_data,
	input  logic [fsab_pkg::CH_W-1:0]     red,
	input  logic [fsab_pkg::CH_W-1:0]     green,
	input  logic [fsab_pkg::CH_W-1:0]     blue,
	input  logic [fsab_pkg::CH_W-1:0]     alpha,
	input  fsab_pkg::cmd_t                cmd,
	output fsab_pkg::status_t             status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [fsab_pkg::COLOR_W-1:0]  color565,
	output logic [fsab_pkg::AREA_W-1:0]   screen_x,
	output logic [fsab_pkg::AREA_W-1:0]   screen_y,
	output logic                          frame_end
);
	import fsab_pkg::*;

	// configuration
	logic [SRC_W-1:0]   src_w_q, src_h_q;
	logic [AREA_W-1:0]  area_w_q, area_h_q;
	logic [MARG_W-1:0]  margin_q;
	logic [COLOR_W-1:0] bg_q;

	// held frame start pixel
	logic [CH_W-1:0] hold_r_q, hold_g_q, hold_b_q, hold_a_q;

	// per-frame setup
	logic [SRC_W-1:0]  frame_w_q, frame_h_q;
	logic [AREA_W-1:0] aw_q, ah_q;
	logic              rej_q;
	logic [PROD_W-1:0] prod_a_q, prod_b_q;
	logic [SRC_W-1:0]  num_q, den_q;
	logic [AREA_W-1:0] draw_w_q, draw_h_q;
	logic [AREA_W-1:0] off_x_q, off_y_q;

	// stream position and scaled index terms
	logic [SRC_W-1:0]  src_col_q, src_row_q;
	logic [AREA_W-1:0] out_col_q, out_row_q;
	logic [ACC_W-1:0]  cs_q, cd_q, rs_q, rd_q;
	logic              row_sel_q;

	// output register
	logic               out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [AREA_W-1:0]  sx_q, sy_q;
	logic               fend_q;

	// divider
	logic [DVD_W-1:0] div_dvd, div_quo;
	logic             div_done;
	logic [SRC_W-1:0] div_size;

	fsab_div #(.DVD_W(DVD_W), .DVS_W(SRC_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_dvd),
		.divisor  (den_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign div_size = cmd.div_h ? frame_h_q : frame_w_q;
	assign div_dvd  = DVD_W'(div_size * num_q);

	logic [AREA_W-1:0] div_draw;
	assign div_draw = (div_quo == '0) ? AREA_W'(1) : div_quo[AREA_W-1:0];

	// size checks and area clamp
	logic [AREA_W-1:0] aw_c, ah_c;
	logic [ACC_W-1:0]  src_area;
	logic              rej_c;

	function automatic logic [AREA_W-1:0] clamp_area(input logic [AREA_W-1:0] a);
		logic [AREA_W-1:0] r;
		r = a;
		if (a == '0) r = AREA_W'(1);
		else if (32'(a) > MAX_AREA_DIM) r = AREA_W'(MAX_AREA_DIM);
		return r;
	endfunction

	assign aw_c     = clamp_area(area_w_q);
	assign ah_c     = clamp_area(area_h_q);
	assign src_area = ACC_W'(src_w_q * src_h_q);
	assign rej_c    = (src_w_q == '0) || (src_h_q == '0) ||
	                  (32'(src_w_q) > MAX_SOURCE_DIM) || (32'(src_h_q) > MAX_SOURCE_DIM) ||
	                  (src_area > PIXEL_LIMIT);

	// scale fraction choice
	logic [SRC_W-1:0] num_c, den_c;
	always_comb begin
		if (prod_a_q <= prod_b_q) begin
			num_c = SRC_W'(aw_q);
			den_c = frame_w_q;
		end else begin
			num_c = SRC_W'(ah_q);
			den_c = frame_h_q;
		end
		if (num_c >= den_c) begin
			num_c = SRC_W'(1);
			den_c = SRC_W'(1);
		end
	end

	// blend over the background with rounding, divide by 255
	function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] c,
			input logic [CH_W-1:0] bg, input logic [CH_W-1:0] a);
		logic [15:0] x;
		logic [16:0] t;
		x = 16'(c * a) + 16'(bg * (ALPHA_OPAQUE - a)) + 16'd127;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	logic [CH_W-1:0] pr, pg, pb, pa;
	logic [CH_W-1:0] bgr, bgg, bgb;
	logic [CH_W-1:0] cr, cg, cb;

	assign pr = cmd.step_hold ? hold_r_q : red;
	assign pg = cmd.step_hold ? hold_g_q : green;
	assign pb = cmd.step_hold ? hold_b_q : blue;
	assign pa = cmd.step_hold ? hold_a_q : alpha;

	assign bgr = {bg_q[15:11], bg_q[15:13]};
	assign bgg = {bg_q[10:5], bg_q[10:9]};
	assign bgb = {bg_q[4:0], bg_q[4:2]};

	always_comb begin
		if (pa < ALPHA_OPAQUE) begin
			cr = blend(pr, bgr, pa);
			cg = blend(pg, bgg, pa);
			cb = blend(pb, bgb, pa);
		end else begin
			cr = pr;
			cg = pg;
			cb = pb;
		end
	end

	// pixel selection
	logic             step;
	logic             emit;
	logic [ACC_W-1:0] num_a, den_a;
	logic             row_end;
	logic [AREA_W-1:0] out_row_n;
	logic [SRC_W-1:0]  src_row_n;
	logic [ACC_W-1:0]  rs_n, rd_n;
	logic              row_sel_n;

	assign step  = cmd.step_in || cmd.step_hold;
	assign num_a = ACC_W'(num_q);
	assign den_a = ACC_W'(den_q);
	assign emit  = !rej_q && row_sel_q && (out_col_q < draw_w_q) &&
	               (cs_q <= cd_q) && (cd_q < cs_q + num_a);

	assign row_end   = ({1'b0, src_col_q} + 1'b1) >= {1'b0, frame_w_q};
	assign out_row_n = row_sel_q ? out_row_q + 1'b1 : out_row_q;
	assign rd_n      = row_sel_q ? rd_q + den_a : rd_q;
	assign src_row_n = (src_row_q < ROW_MAX) ? src_row_q + 1'b1 : src_row_q;
	assign rs_n      = (src_row_q < ROW_MAX) ? rs_q + num_a : rs_q;
	assign row_sel_n = !rej_q && (out_row_n < draw_h_q) && (rs_n <= rd_n) &&
	                   (rd_n < rs_n + num_a);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= SRC_W'(1);
			src_h_q  <= SRC_W'(1);
			area_w_q <= AREA_W'(236);
			area_h_q <= AREA_W'(396);
			margin_q <= MARG_W'(2);
			bg_q     <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE_WIDTH:  src_w_q  <= cfg_data[SRC_W-1:0];
				CFG_SOURCE_HEIGHT: src_h_q  <= cfg_data[SRC_W-1:0];
				CFG_AREA_WIDTH:    area_w_q <= cfg_data[AREA_W-1:0];
				CFG_AREA_HEIGHT:   area_h_q <= cfg_data[AREA_W-1:0];
				CFG_MARGIN:        margin_q <= cfg_data[MARG_W-1:0];
				CFG_BACKGROUND:    bg_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// held pixel
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			hold_r_q <= red;
			hold_g_q <= green;
			hold_b_q <= blue;
			hold_a_q <= alpha;
		end
	end

	// cross products for the scale choice
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			prod_a_q <= PROD_W'(aw_c * src_h_q);
			prod_b_q <= PROD_W'(ah_c * src_w_q);
		end
	end

	// frame setup and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= SRC_W'(1);
			frame_h_q <= SRC_W'(1);
			aw_q      <= AREA_W'(1);
			ah_q      <= AREA_W'(1);
			rej_q     <= 1'b0;
			num_q     <= SRC_W'(1);
			den_q     <= SRC_W'(1);
			draw_w_q  <= AREA_W'(1);
			draw_h_q  <= AREA_W'(1);
			off_x_q   <= '0;
			off_y_q   <= '0;
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cs_q      <= '0;
			cd_q      <= '0;
			rs_q      <= '0;
			rd_q      <= '0;
			row_sel_q <= 1'b0;
		end else begin
			if (cmd.calc) begin
				frame_w_q <= (src_w_q == '0) ? SRC_W'(1) : src_w_q;
				frame_h_q <= (src_h_q == '0) ? SRC_W'(1) : src_h_q;
				aw_q      <= aw_c;
				ah_q      <= ah_c;
				rej_q     <= rej_c;
			end
			if (cmd.scale && !rej_q) begin
				num_q <= num_c;
				den_q <= den_c;
			end
			if (cmd.cap_w) draw_w_q <= div_draw;
			if (cmd.cap_h) draw_h_q <= div_draw;
			if (cmd.fin) begin
				off_x_q   <= AREA_W'(margin_q) + ((aw_q - draw_w_q) >> 1);
				off_y_q   <= AREA_W'(margin_q) + ((ah_q - draw_h_q) >> 1);
				src_col_q <= '0;
				src_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				cs_q      <= '0;
				cd_q      <= '0;
				rs_q      <= '0;
				rd_q      <= '0;
				row_sel_q <= !rej_q;
			end
			if (step) begin
				if (row_end) begin
					src_col_q <= '0;
					cs_q      <= '0;
					out_col_q <= '0;
					cd_q      <= '0;
					out_row_q <= out_row_n;
					rd_q      <= rd_n;
					src_row_q <= src_row_n;
					rs_q      <= rs_n;
					row_sel_q <= row_sel_n;
				end else begin
					src_col_q <= src_col_q + 1'b1;
					cs_q      <= cs_q + num_a;
					if (emit) begin
						out_col_q <= out_col_q + 1'b1;
						cd_q      <= cd_q + den_a;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (step && emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			color_q <= {cr[7:3], cg[7:2], cb[7:3]};
			sx_q    <= off_x_q + out_col_q;
			sy_q    <= off_y_q + out_row_q;
			fend_q  <= (out_col_q + 1'b1 == draw_w_q) && (out_row_q + 1'b1 == draw_h_q);
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.rejected = rej_q;
	assign status.div_done = div_done;

	assign out_valid = out_valid_q;
	assign color565  = color_q;
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;
	assign frame_end = fend_q;

endmodule

// ===== rtl/core/fit_scale_alpha_blend_rgb565.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    red, green, blue, alpha, frame_start
// output    out_valid / out_ready  color565, screen_x, screen_y, frame_end
// config    cfg_we                 cfg_index, cfg_data
//
// An ordinary pixel is accepted in the idle state; if it is drawn, its result is
// registered at the same edge. A new pixel is accepted every cycle while the output
// register drains. A frame start pixel holds the input through the calc, scale,
// division and offset states until the held pixel is processed. The draw width and
// height come from one shared bit-serial divider; a rejected frame start skips them.
// Reset (arst_n low) restores register defaults and the no-frame state.
// A stalled output holds its result and blocks input acceptance.
module fit_scale_alpha_blend_rgb565 #(
	parameter int MAX_SOURCE_DIM = 4096,
	parameter int MAX_AREA_DIM   = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fsab_pkg::CH_W-1:0]     red,
	input  logic [fsab_pkg::CH_W-1:0]     green,
	input  logic [fsab_pkg::CH_W-1:0]     blue,
	input  logic [fsab_pkg::CH_W-1:0]     alpha,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fsab_pkg::COLOR_W-1:0]  color565,
	output logic [fsab_pkg::AREA_W-1:0]   screen_x,
	output logic [fsab_pkg::AREA_W-1:0]   screen_y,
	output logic                          frame_end,
	input  logic                          cfg_we,
	input  logic [fsab_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [fsab_pkg::CDATA_W-1:0]  cfg_data
);
	import fsab_pkg::*;

	cmd_t    cmd;
	status_t status;

	fsab_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.frame_start (frame_start),
		.in_ready    (in_ready),
		.status      (status),
		.cmd         (cmd)
	);

	fsab_dp #(
		.MAX_SOURCE_DIM (MAX_SOURCE_DIM),
		.MAX_AREA_DIM   (MAX_AREA_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.color565  (color565),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.frame_end (frame_end)
	);

endmodule
